FILE: rtl/tolerant_base64_decoder_top_defines.svh
// Assertion macros used by the port checker of the base64 decoder.
`ifndef TOLERANT_BASE64_DECODER_TOP_DEFINES_SVH
`define TOLERANT_BASE64_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define B64D_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("base64 decoder port check failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define B64D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("base64 decoder port check failed");

`endif

FILE: rtl/b64d_pkg.sv
// Types and constants shared by the base64 decoder modules.
package b64d_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SYMBOL_62 = 2'd0,
    REG_SYMBOL_63 = 2'd1,
    REG_PAD       = 2'd2
  } reg_index_t;

  localparam logic [7:0] SYMBOL_62_DEFAULT = 8'd43;
  localparam logic [7:0] SYMBOL_63_DEFAULT = 8'd47;
  localparam logic [7:0] PAD_DEFAULT       = 8'd61;
  localparam logic [2:0] GROUP_SYMBOLS     = 3'd4;

  // One unit of work handed from the front to the back: the data bytes of a
  // finished group (byte_count of them, top byte first) and an optional
  // end-of-message status.
  typedef struct packed {
    logic [23:0] group_bits;
    logic [1:0]  byte_count;
    logic        status;
    logic        error;
  } entry_t;

endpackage

FILE: rtl/b64d_char_if.sv
// Character input channel of the base64 decoder.
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_message;

  modport source (output valid, output text_char, output end_of_message, input ready);
  modport sink (input valid, input text_char, input end_of_message, output ready);
endinterface

FILE: rtl/b64d_result_if.sv
// Result output channel of the base64 decoder.
interface b64d_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       has_byte;
  logic       msg_done;
  logic       decode_error;

  modport source (output valid, output byte_value, output has_byte, output msg_done,
                  output decode_error, input ready);
  modport sink (input valid, input byte_value, input has_byte, input msg_done,
                input decode_error, output ready);
endinterface

FILE: rtl/tolerant_base64_decoder_top.sv
// Top level of the tolerant base64 decoder.
//
// The decoder takes one character of base64 text per transfer on char_stream
// (text_char, end_of_message) and delivers results on result_stream. Each
// finished four-symbol group yields three, two or one data bytes (has_byte
// set), and the last character of a message yields one status result
// (msg_done set, decode_error telling whether the message was malformed).
// The three alphabet registers are written through cfg_write, cfg_index and
// cfg_data; the user must write them only while the block is idle, which the
// block does not enforce. A register holding zero acts as its default. The
// results of a character pass through the work queue and then the output
// register. A character is accepted every cycle while the work queue has room;
// the result port delivers one result per cycle while the receiver takes them,
// so a burst of up to four results from one character is taken up by the
// QUEUE_DEPTH-entry queue between the front end and the back end. When the
// receiver stalls, the output register holds its result and the queue fills;
// char_stream.ready falls only when the queue is full. Reset restores the default
// alphabet, clears the group state and empties the queue and the output register.
module tolerant_base64_decoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  b64d_char_if.sink     char_stream,
  b64d_result_if.source result_stream
);

  logic             push;
  b64d_pkg::entry_t push_entry;
  logic             pop;
  b64d_pkg::entry_t head;
  logic             not_empty;
  logic             queue_full;

  // Front end classifies each character and builds group and status entries.
  b64d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .char_stream (char_stream),
    .queue_full  (queue_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  // The queue lets the input keep flowing while the back end drains bursts.
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .full       (queue_full)
  );

  // Back end sends one result per cycle from the head entry unless the receiver stalls.
  b64d_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .not_empty     (not_empty),
    .pop           (pop),
    .result_stream (result_stream)
  );

endmodule

FILE: rtl/b64d_front.sv
// Front end: configuration, character classification and group assembly.
module b64d_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  b64d_char_if.sink           char_stream,
  input  logic                queue_full,
  output logic                push,
  output b64d_pkg::entry_t    push_entry
);

  logic [7:0]  symbol_62_char;
  logic [7:0]  symbol_63_char;
  logic [7:0]  pad_char;
  logic [23:0] group_bits;
  logic [2:0]  symbols_left;
  logic [1:0]  pad_count;
  logic        error_seen;

  logic [7:0]  s62_eff;
  logic [7:0]  s63_eff;
  logic [7:0]  pad_eff;
  logic [7:0]  c;
  logic [5:0]  sym;
  logic        is_sym;
  logic        is_space;
  logic        accept;
  logic        last;

  logic [23:0] gb_step;
  logic [2:0]  sl_step;
  logic [1:0]  pc_step;
  logic        err_step;
  logic        group_full;
  logic [23:0] gb_after;
  logic [2:0]  sl_after;
  logic [1:0]  pc_after;
  logic        err_final;
  logic        have_group;
  logic [23:0] out_bits;
  logic [1:0]  out_pads;

  logic [23:0] group_bits_next;
  logic [2:0]  symbols_left_next;
  logic [1:0]  pad_count_next;
  logic        error_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_62_char <= b64d_pkg::SYMBOL_62_DEFAULT;
      symbol_63_char <= b64d_pkg::SYMBOL_63_DEFAULT;
      pad_char       <= b64d_pkg::PAD_DEFAULT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        b64d_pkg::REG_SYMBOL_62: symbol_62_char <= cfg_data;
        b64d_pkg::REG_SYMBOL_63: symbol_63_char <= cfg_data;
        b64d_pkg::REG_PAD:       pad_char       <= cfg_data;
        default: ;
      endcase
    end
  end

  // A register holding zero behaves as its default.
  assign s62_eff = (symbol_62_char != 8'd0) ? symbol_62_char : b64d_pkg::SYMBOL_62_DEFAULT;
  assign s63_eff = (symbol_63_char != 8'd0) ? symbol_63_char : b64d_pkg::SYMBOL_63_DEFAULT;
  assign pad_eff = (pad_char != 8'd0) ? pad_char : b64d_pkg::PAD_DEFAULT;

  assign c      = char_stream.text_char;
  assign last   = char_stream.end_of_message;
  assign accept = char_stream.valid && char_stream.ready;
  assign char_stream.ready = !queue_full;

  // Symbol decode; the programmable characters override the fixed ranges.
  always_comb begin
    sym    = 6'd0;
    is_sym = 1'b0;
    if (c >= 8'd65 && c <= 8'd90) begin
      sym = 6'(c - 8'd65);
      is_sym = 1'b1;
    end else if (c >= 8'd97 && c <= 8'd122) begin
      sym = 6'(c - 8'd71);
      is_sym = 1'b1;
    end else if (c >= 8'd48 && c <= 8'd57) begin
      sym = 6'(c + 8'd4);
      is_sym = 1'b1;
    end
    if (c == s62_eff) begin
      sym = 6'd62;
      is_sym = 1'b1;
    end
    if (c == s63_eff) begin
      sym = 6'd63;
      is_sym = 1'b1;
    end
  end

  assign is_space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);

  // Effect of the character itself.
  always_comb begin
    gb_step  = group_bits;
    sl_step  = symbols_left;
    pc_step  = pad_count;
    err_step = error_seen;
    if (!error_seen) begin
      priority if (is_sym) begin
        if (pad_count != 2'd0) begin
          err_step = 1'b1;
        end else begin
          gb_step = {group_bits[17:0], sym};
          sl_step = symbols_left - 3'd1;
        end
      end else if (c == 8'd0) begin
        err_step = 1'b1;
      end else if (c == pad_eff) begin
        if (symbols_left == 3'd3) begin
          err_step = 1'b1;
        end else if (symbols_left != b64d_pkg::GROUP_SYMBOLS) begin
          gb_step = {group_bits[17:0], 6'd0};
          pc_step = pad_count + 2'd1;
          sl_step = symbols_left - 3'd1;
        end
      end else if (!is_space) begin
        err_step = 1'b1;
      end
    end
  end

  assign group_full = !err_step && (sl_step == 3'd0);
  assign gb_after   = group_full ? 24'd0 : gb_step;
  assign sl_after   = group_full ? b64d_pkg::GROUP_SYMBOLS : sl_step;
  assign pc_after   = group_full ? 2'd0 : pc_step;

  // Message end: an unpadded tail of two or three symbols is padded out; a lone symbol is an error.
  always_comb begin
    err_final  = err_step;
    have_group = group_full;
    out_bits   = gb_step;
    out_pads   = pc_step;
    if (last && !err_step) begin
      if (sl_after == 3'd3) begin
        err_final = 1'b1;
      end else if (sl_after == 3'd2) begin
        have_group = 1'b1;
        out_bits   = {gb_after[11:0], 12'd0};
        out_pads   = pc_after + 2'd2;
      end else if (sl_after == 3'd1) begin
        have_group = 1'b1;
        out_bits   = {gb_after[17:0], 6'd0};
        out_pads   = pc_after + 2'd1;
      end
    end
  end

  assign push = accept && (have_group || last);

  always_comb begin
    push_entry.group_bits = out_bits;
    push_entry.byte_count = have_group ? (2'd3 - out_pads) : 2'd0;
    push_entry.status     = last;
    push_entry.error      = err_final;
  end

  always_comb begin
    if (last) begin
      group_bits_next   = 24'd0;
      symbols_left_next = b64d_pkg::GROUP_SYMBOLS;
      pad_count_next    = 2'd0;
      error_seen_next   = 1'b0;
    end else begin
      group_bits_next   = gb_after;
      symbols_left_next = sl_after;
      pad_count_next    = pc_after;
      error_seen_next   = err_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bits   <= 24'd0;
      symbols_left <= b64d_pkg::GROUP_SYMBOLS;
      pad_count    <= 2'd0;
      error_seen   <= 1'b0;
    end else if (accept) begin
      group_bits   <= group_bits_next;
      symbols_left <= symbols_left_next;
      pad_count    <= pad_count_next;
      error_seen   <= error_seen_next;
    end
  end

endmodule

FILE: rtl/b64d_queue.sv
// Small first-in first-out queue of work entries between front and back.
module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64d_pkg::entry_t push_entry,
  input  logic             pop,
  output b64d_pkg::entry_t head,
  output logic             not_empty,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  b64d_pkg::entry_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == FULL_COUNT);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/b64d_back.sv
// Back end: unpacks queue entries into byte and status results.
module b64d_back (
  input  logic             clk,
  input  logic             rst,
  input  b64d_pkg::entry_t head,
  input  logic             not_empty,
  output logic             pop,
  b64d_result_if.source    result_stream
);

  logic [1:0] pos;
  logic       out_valid;
  logic [7:0] byte_value;
  logic       has_byte;
  logic       msg_done;
  logic       decode_error;

  logic       advance;
  logic [2:0] total;
  logic       is_byte;
  logic       last_of_entry;
  logic [7:0] sel_byte;

  assign advance = not_empty && (!out_valid || result_stream.ready);
  assign total   = {1'b0, head.byte_count} + {2'b00, head.status};
  assign is_byte = (pos < head.byte_count);
  assign last_of_entry = ({1'b0, pos} + 3'd1 == total);
  assign pop = advance && last_of_entry;

  always_comb begin
    unique case (pos)
      2'd0:    sel_byte = head.group_bits[23:16];
      2'd1:    sel_byte = head.group_bits[15:8];
      default: sel_byte = head.group_bits[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        pos       <= last_of_entry ? 2'd0 : pos + 2'd1;
        out_valid <= 1'b1;
      end else if (result_stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_value   <= is_byte ? sel_byte : 8'd0;
      has_byte     <= is_byte;
      msg_done     <= !is_byte;
      decode_error <= !is_byte && head.error;
    end
  end

  assign result_stream.valid        = out_valid;
  assign result_stream.byte_value   = byte_value;
  assign result_stream.has_byte     = has_byte;
  assign result_stream.msg_done     = msg_done;
  assign result_stream.decode_error = decode_error;

endmodule

FILE: rtl/b64d_port_checker.sv
// Port-level checks of the base64 decoder and their binding to the top level.
`include "tolerant_base64_decoder_top_defines.svh"

module b64d_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] byte_value,
  input logic       has_byte,
  input logic       msg_done,
  input logic       decode_error
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // A stalled result stays offered and unchanged.
  `B64D_ASSERT_NEXT(result_held, out_valid && !out_ready,
    out_valid && $stable(byte_value) && $stable(has_byte) && $stable(msg_done) && $stable(decode_error))

  // A data byte is never a status result and never carries an error.
  `B64D_ASSERT_NOW(byte_flags, out_valid && has_byte, !msg_done && !decode_error)

  // With in_xfer low now and in its past value, an idle output stays idle.
  `B64D_ASSERT_NEXT(idle_stays_idle, !out_valid && !in_xfer && !$past(in_xfer), !out_valid)

endmodule

bind tolerant_base64_decoder_top b64d_port_checker u_port_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (char_stream.valid),
  .in_ready     (char_stream.ready),
  .out_valid    (result_stream.valid),
  .out_ready    (result_stream.ready),
  .byte_value   (result_stream.byte_value),
  .has_byte     (result_stream.has_byte),
  .msg_done     (result_stream.msg_done),
  .decode_error (result_stream.decode_error)
);

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the tolerant base64 decoder, comparing its results with a predictor.
module testbench;

  typedef logic [7:0] char_t;

  // One character transfer as it is offered on the input channel.
  typedef struct {
    char_t ch;
    logic  eom;
  } text_item_t;

  // One result transfer: a data byte or the status that closes a message.
  typedef struct {
    char_t byte_value;
    logic  has_byte;
    logic  msg_done;
    logic  decode_error;
  } out_item_t;

  // How the two ends of the block idle during a phase of the run.
  typedef enum {
    FLOW_FREE,
    FLOW_SENDER_GAPS,
    FLOW_RECEIVER_STALLS,
    FLOW_BOTH
  } flow_t;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS  = 100;
  localparam int FINAL_WAIT   = 5000;

  logic  clk;
  logic  rst;
  logic  cfg_write;
  logic  [1:0] cfg_index;
  char_t cfg_data;

  b64d_char_if   chr();
  b64d_result_if res();

  tolerant_base64_decoder_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .char_stream   (chr),
    .result_stream (res)
  );

  // Alphabet registers as the block should hold them.
  char_t alpha62;
  char_t alpha63;
  char_t pad_sym;

  // Group state of the decoder as the predictor tracks it.
  logic [23:0] grp_bits;
  logic [2:0]  syms_left;
  logic [1:0]  pads_seen;
  logic        err_latched;

  text_item_t text_q[$];            // characters still to be offered
  out_item_t  decoder_output_q[$];  // bytes and statuses the block still owes
  text_item_t cur;                  // character now on the input channel

  flow_t flow = FLOW_FREE;
  logic  hold_armed = 1'b0;
  logic  hold_done;
  int    hold_left;

  int cycle_count   = 0;
  int mismatches    = 0;
  int phase_items   = 0;
  int chars_sent    = 0;
  int bytes_seen    = 0;
  int statuses_seen = 0;
  int bad_statuses  = 0;
  int input_stalls  = 0;

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit: a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped: no progress after %0d cycles", cycle_count);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic char_t eff(input char_t r, input char_t dflt);
    return (r != 8'd0) ? r : dflt;
  endfunction

  function automatic bit is_space(input char_t c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Value of a character in the current alphabet, or -1 when it is no symbol.
  // The two programmable characters override the fixed ranges, and the
  // value-63 character wins when both registers hold the same one.
  function automatic int symbol_of(input char_t c);
    int v;
    v = -1;
    if (c >= "A" && c <= "Z") v = c - "A";
    else if (c >= "a" && c <= "z") v = c - "a" + 26;
    else if (c >= "0" && c <= "9") v = c - "0" + 52;
    if (c == eff(alpha62, b64d_pkg::SYMBOL_62_DEFAULT)) v = 62;
    if (c == eff(alpha63, b64d_pkg::SYMBOL_63_DEFAULT)) v = 63;
    return v;
  endfunction

  task automatic clear_group();
    grp_bits  = '0;
    syms_left = b64d_pkg::GROUP_SYMBOLS;
    pads_seen = '0;
  endtask

  task automatic push_out(input char_t b, input logic hb, input logic done, input logic e);
    out_item_t o;
    o.byte_value   = b;
    o.has_byte     = hb;
    o.msg_done     = done;
    o.decode_error = e;
    decoder_output_q.push_back(o);
  endtask

  // A full group gives three bytes, one fewer for each pad in it.
  task automatic flush_group();
    push_out(grp_bits[23:16], 1'b1, 1'b0, 1'b0);
    if (pads_seen < 2'd2) push_out(grp_bits[15:8], 1'b1, 1'b0, 1'b0);
    if (pads_seen < 2'd1) push_out(grp_bits[7:0], 1'b1, 1'b0, 1'b0);
    clear_group();
  endtask

  // Works out what one accepted character makes the block emit.
  task automatic decode_char(input char_t c, input logic eom);
    int    v;
    char_t pc;
    pc = eff(pad_sym, b64d_pkg::PAD_DEFAULT);
    v  = symbol_of(c);
    if (!err_latched) begin
      if (v >= 0) begin
        // A symbol that follows a pad in the same group is malformed.
        if (pads_seen != 2'd0) begin
          err_latched = 1'b1;
        end else begin
          grp_bits  = {grp_bits[17:0], 6'(v)};
          syms_left = syms_left - 3'd1;
        end
      end else if (c == 8'd0) begin
        err_latched = 1'b1;
      end else if (c == pc) begin
        // A pad right after the first symbol is an error; one at the start
        // of a group is skipped; later ones shift in zero bits.
        if (syms_left == 3'd3) begin
          err_latched = 1'b1;
        end else if (syms_left != b64d_pkg::GROUP_SYMBOLS) begin
          grp_bits  = {grp_bits[17:0], 6'd0};
          pads_seen = pads_seen + 2'd1;
          syms_left = syms_left - 3'd1;
        end
      end else if (!is_space(c)) begin
        err_latched = 1'b1;
      end
      if (!err_latched && syms_left == 3'd0) flush_group();
    end
    if (eom) begin
      // A tail of two or three symbols is completed as if padded; a lone
      // symbol cannot make a byte.
      if (!err_latched) begin
        if (syms_left == 3'd3) begin
          err_latched = 1'b1;
        end else if (syms_left == 3'd1 || syms_left == 3'd2) begin
          grp_bits  = grp_bits << (6 * syms_left);
          pads_seen = pads_seen + syms_left[1:0];
          flush_group();
        end
      end
      push_out(8'd0, 1'b0, 1'b1, err_latched);
      clear_group();
      err_latched = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  function automatic bit roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // The driver keeps a character on the channel until it is taken, and
  // predicts its results at the edge of the transfer.
  always @(posedge clk) begin
    if (rst) begin
      chr.valid <= 1'b0;
    end else begin
      if (chr.valid && chr.ready) begin
        decode_char(cur.ch, cur.eom);
        chars_sent++;
      end
      if (chr.valid && !chr.ready) input_stalls++;
      if (!chr.valid || chr.ready) begin
        if (text_q.size() != 0 &&
            !roll((flow == FLOW_SENDER_GAPS) ? 86 : (flow == FLOW_BOTH) ? 28 : 0)) begin
          cur = text_q.pop_front();
          chr.valid          <= 1'b1;
          chr.text_char      <= cur.ch;
          chr.end_of_message <= cur.eom;
        end else begin
          chr.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_result();
    out_item_t want;
    if (res.has_byte) bytes_seen++;
    if (res.msg_done) begin
      statuses_seen++;
      if (res.decode_error) bad_statuses++;
    end
    if (decoder_output_q.size() == 0) begin
      flag_mismatch($sformatf("result with nothing owed: byte %02h has_byte %0b msg_done %0b",
                              res.byte_value, res.has_byte, res.msg_done));
    end else begin
      want = decoder_output_q.pop_front();
      if (res.byte_value !== want.byte_value)
        flag_mismatch($sformatf("byte_value %02h, predicted %02h", res.byte_value,
                                want.byte_value));
      if (res.has_byte !== want.has_byte)
        flag_mismatch($sformatf("has_byte %0b, predicted %0b", res.has_byte, want.has_byte));
      if (res.msg_done !== want.msg_done)
        flag_mismatch($sformatf("msg_done %0b, predicted %0b", res.msg_done, want.msg_done));
      if (res.decode_error !== want.decode_error)
        flag_mismatch($sformatf("decode_error %0b, predicted %0b", res.decode_error,
                                want.decode_error));
    end
  endtask

  // The long receiver hold is timed here; it starts once when armed.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // The monitor checks each result transfer and then decides whether to
  // take the next one.
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) check_result();
      res.ready <= (hold_left == 0) &&
                   !roll((flow == FLOW_RECEIVER_STALLS) ? 86 : (flow == FLOW_BOTH) ? 28 : 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic char_t space_char();
    int v;
    v = $urandom_range(0, 5);
    return (v == 5) ? 8'd32 : char_t'(9 + v);
  endfunction

  // Character that carries value v in the current alphabet.
  function automatic char_t sym_char(input int v);
    if (v < 26) return char_t'("A" + v);
    if (v < 52) return char_t'("a" + v - 26);
    if (v < 62) return char_t'("0" + v - 52);
    if (v == 62) return eff(alpha62, b64d_pkg::SYMBOL_62_DEFAULT);
    return eff(alpha63, b64d_pkg::SYMBOL_63_DEFAULT);
  endfunction

  // Mostly characters that mean something to the decoder, the rest any byte.
  function automatic char_t noise_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return sym_char($urandom_range(0, 63));
    if (r < 55) return eff(pad_sym, b64d_pkg::PAD_DEFAULT);
    if (r < 70) return space_char();
    return char_t'($urandom_range(0, 255));
  endfunction

  // Queues a message; its last character carries the end mark.
  task automatic add_text(input char_t txt[$]);
    if (txt.size() == 0) txt.push_back(space_char());
    foreach (txt[i]) begin
      text_q.push_back(text_item_t'{ch: txt[i], eom: (i == txt.size() - 1)});
      if (!is_space(txt[i])) phase_items++;
    end
  endtask

  task automatic add_string(input string s);
    char_t txt[$];
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    add_text(txt);
  endtask

  // Encodes random bytes in the current alphabet, padded or with a bare
  // tail, with stray whitespace and now and then a pad before a group.
  task automatic build_encoded(output char_t txt[$], input int nbytes, input bit padded);
    logic [23:0] bits;
    int          rem;
    int          nsym;
    txt = {};
    for (int i = 0; i < nbytes; i += 3) begin
      rem  = nbytes - i;
      bits = {8'($urandom), 8'($urandom), 8'($urandom)};
      if (rem < 3) bits[7:0] = 8'd0;
      if (rem < 2) bits[15:8] = 8'd0;
      nsym = (rem >= 3) ? 4 : rem + 1;
      if ($urandom_range(0, 9) == 0) txt.push_back(eff(pad_sym, b64d_pkg::PAD_DEFAULT));
      for (int k = 0; k < nsym; k++) begin
        txt.push_back(sym_char(bits[23 - 6 * k -: 6]));
        if ($urandom_range(0, 7) == 0) txt.push_back(space_char());
      end
      if (padded) repeat (4 - nsym) txt.push_back(eff(pad_sym, b64d_pkg::PAD_DEFAULT));
    end
  endtask

  // Most messages are well formed so that decoding gets deep into groups;
  // some are damaged and the rest are plain noise.
  task automatic add_random_message();
    char_t txt[$];
    int    r;
    int    pos;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      build_encoded(txt, ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                                      : $urandom_range(0, 12),
                    $urandom_range(0, 1));
      if (r >= 65 && txt.size() != 0) begin
        pos = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 2))
          0: begin
            txt[pos] = noise_char();
          end
          1: begin
            txt.insert(pos, eff(pad_sym, b64d_pkg::PAD_DEFAULT));
          end
          default: begin
            while (txt.size() > pos + 1) void'(txt.pop_back());
          end
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 8)) txt.push_back(noise_char());
    end
    add_text(txt);
  endtask

  // Waits until every character went in and every result came out, then
  // gives characters that owe no result time to leave the block.
  task automatic wait_quiet();
    while (text_q.size() != 0 || chr.valid || decoder_output_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input b64d_pkg::reg_index_t idx, input char_t val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      b64d_pkg::REG_SYMBOL_62: alpha62 = val;
      b64d_pkg::REG_SYMBOL_63: alpha63 = val;
      default:                 pad_sym = val;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // A phase sets the alphabet while the block is idle, then chooses how
  // both ends idle and queues any directed messages and then its random ones.
  task automatic run_phase(input flow_t f, input char_t c62, input char_t c63, input char_t cpad,
                           input bit directed);
    wait_quiet();
    write_reg(b64d_pkg::REG_SYMBOL_62, c62);
    write_reg(b64d_pkg::REG_SYMBOL_63, c63);
    write_reg(b64d_pkg::REG_PAD, cpad);
    flow        = f;
    phase_items = 0;
    if (directed) begin
      add_string("////");   // all ones
      add_string("AA==");   // all zeros, two pads
      add_string("=+w");    // pad at group start skipped, two-symbol tail
      add_string("A=");     // pad in second position
      add_string("Q");      // lone symbol at message end
      add_string("AB=C");   // symbol after a pad
      text_q.push_back(text_item_t'{ch: 8'd0, eom: 1'b1});  // NUL as the final character
      add_string("*A");     // stray character, later symbols ignored
      add_string("AB\tC");  // whitespace inside a three-symbol tail
    end
    while (phase_items < PHASE_ITEMS) add_random_message();
  endtask

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = b64d_pkg::REG_SYMBOL_62;
    cfg_data  = 8'd0;
    chr.valid          = 1'b0;
    chr.text_char      = 8'd0;
    chr.end_of_message = 1'b0;
    res.ready          = 1'b0;
    alpha62     = b64d_pkg::SYMBOL_62_DEFAULT;
    alpha63     = b64d_pkg::SYMBOL_63_DEFAULT;
    pad_sym     = b64d_pkg::PAD_DEFAULT;
    err_latched = 1'b0;
    clear_group();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Default alphabet, no idling, and one long receiver hold so that the
    // result queue fills and the input channel is held off.
    run_phase(FLOW_FREE, b64d_pkg::SYMBOL_62_DEFAULT, b64d_pkg::SYMBOL_63_DEFAULT,
              b64d_pkg::PAD_DEFAULT, 1'b1);
    hold_armed = 1'b1;
    // URL-safe alphabet with sender gaps.
    run_phase(FLOW_SENDER_GAPS, "-", "_", b64d_pkg::PAD_DEFAULT, 1'b0);
    // Register extremes, with the space character acting as pad.
    run_phase(FLOW_RECEIVER_STALLS, 8'd1, 8'd255, " ", 1'b0);
    // Both symbol registers on one letter and the pad on the top code.
    run_phase(FLOW_BOTH, "A", "A", 8'd255, 1'b0);
    // Random alphabet, no idling.
    run_phase(FLOW_FREE, char_t'($urandom_range(1, 255)), char_t'($urandom_range(1, 255)),
              char_t'($urandom_range(1, 255)), 1'b0);

    // Everything is queued: wait for the input side, then for the results
    // still owed, within a bound, and a little longer for strays.
    while (text_q.size() != 0 || chr.valid) @(posedge clk);
    for (int w = 0; w < FINAL_WAIT && decoder_output_q.size() != 0; w++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decoder_output_q.size() != 0)
      flag_mismatch($sformatf("%0d predicted results never arrived", decoder_output_q.size()));

    $display("summary: %0d characters gave %0d bytes and %0d statuses (%0d malformed)",
             chars_sent, bytes_seen, statuses_seen, bad_statuses);
    $display("summary: five alphabet settings, %0d cycles of input held off, %0d mismatches",
             input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/b64d_pkg.sv
rtl/b64d_char_if.sv
rtl/b64d_result_if.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/tolerant_base64_decoder_top.sv
rtl/b64d_port_checker.sv
bench/testbench.sv
